[src/bpc_pkg.sv]
// Package: shared types, codes and constants of the banded PI pressure controller.
package bpc_pkg;

    // Field and port widths
    localparam int BPC_CMD_W      = 2;
    localparam int BPC_LEVEL_W    = 16;
    localparam int BPC_DRIVE_W    = 10;
    localparam int BPC_CFG_IDX_W  = 3;
    localparam int BPC_CFG_DATA_W = 16;
    localparam int BPC_GAIN_W     = 16;
    localparam int BPC_MULT_W     = 8;

    // Default integrator fraction width
    localparam int BPC_FRAC_BITS  = 16;

    // Command codes
    localparam logic [BPC_CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [BPC_CMD_W-1:0] CMD_AUTO   = 2'd1;
    localparam logic [BPC_CMD_W-1:0] CMD_MANUAL = 2'd2;

    // Configuration register indexes
    localparam logic [BPC_CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [BPC_CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [BPC_CFG_IDX_W-1:0] CFG_BAND_MULT   = 3'd2;
    localparam logic [BPC_CFG_IDX_W-1:0] CFG_REVERSE     = 3'd3;
    localparam logic [BPC_CFG_IDX_W-1:0] CFG_HOLD_MIN    = 3'd4;
    localparam logic [BPC_CFG_IDX_W-1:0] CFG_HOLD_MAX    = 3'd5;

    // Register reset values
    localparam logic [BPC_LEVEL_W-1:0] BPC_HOLD_MAX_RST = 16'd255;

    // Band limits on the error magnitude
    localparam int BPC_BAND_MID_MIN  = 256;
    localparam int BPC_BAND_HIGH_MIN = 2048;

    // Integrator snap points, in integer units
    localparam int BPC_SNAP_HI      = 852;
    localparam int BPC_JUMP_DOWN_TO = 409;
    localparam int BPC_SNAP_LO      = 171;
    localparam int BPC_JUMP_UP_TO   = 614;

    // Drive limit
    localparam int BPC_DRIVE_MAX = 1023;

    // Integral divisors are 125 times a power of two; the odd factor is
    // removed by reciprocal multiplication
    localparam int BPC_DIV_BASE = 125;

    // Datapath commands from the controller
    typedef struct packed {
        logic latch;
        logic mode;
        logic mul1;
        logic mul2;
        logic mul3;
        logic div_step;
        logic update;
        logic load_out;
    } t_dp_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic sample_auto;
        logic div_last;
    } t_dp_stat;

endpackage

[src/bpc_in_if.sv]
// Interface: input sample channel with valid/ready handshake.
interface bpc_in_if import bpc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BPC_CMD_W-1:0]   command;
    logic [BPC_LEVEL_W-1:0] target_level;
    logic [BPC_LEVEL_W-1:0] measured_level;
    logic [BPC_LEVEL_W-1:0] held_drive;

    modport source (
        output valid, command, target_level, measured_level, held_drive,
        input  ready
    );
    modport sink (
        input  valid, command, target_level, measured_level, held_drive,
        output ready
    );
endinterface

[src/bpc_out_if.sv]
// Interface: result channel with valid/ready handshake.
interface bpc_out_if import bpc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BPC_DRIVE_W-1:0] drive_value;
    logic                   drive_updated;

    modport source (
        output valid, drive_value, drive_updated,
        input  ready
    );
    modport sink (
        input  valid, drive_value, drive_updated,
        output ready
    );
endinterface

[src/bpc_datapath.sv]
// Datapath: configuration registers, controller state, multipliers and reciprocal divider.
module bpc_datapath import bpc_pkg::*; #(
    parameter int FRAC_BITS = BPC_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [BPC_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BPC_CFG_DATA_W-1:0] i_cfg_data,
    input  logic [BPC_CMD_W-1:0]      i_command,
    input  logic [BPC_LEVEL_W-1:0]    i_target_level,
    input  logic [BPC_LEVEL_W-1:0]    i_measured_level,
    input  logic [BPC_LEVEL_W-1:0]    i_held_drive,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    output logic [BPC_DRIVE_W-1:0]    o_drive_value,
    output logic                      o_drive_updated
);

    localparam int IW    = BPC_LEVEL_W + FRAC_BITS;          // integrator
    localparam int EW    = BPC_LEVEL_W + 1;                  // raw error
    localparam int ES_W  = 12;                               // banded error
    localparam int MAG_W = ES_W - 1;
    localparam int P1_W  = BPC_GAIN_W + MAG_W;
    localparam int XW    = P1_W + BPC_MULT_W;                // ki*|e|*mult

    // Divide by 125 in stages: 2^18 = 125*2097 + 19 folds the high part of
    // the dividend into a 22-bit value, which a reciprocal multiply divides;
    // the remainder then yields the fraction bits by a second reciprocal
    localparam int DIV_SPLIT = 18;
    localparam int DIV_HI_Q  = (1 << DIV_SPLIT) / BPC_DIV_BASE;
    localparam int DIV_FOLD  = (1 << DIV_SPLIT) % BPC_DIV_BASE;
    localparam int XH_W      = XW - DIV_SPLIT;
    localparam int Q1_W      = XH_W + 12;                    // dividend / 125
    localparam int Y_W       = 22;                           // folded value
    localparam int QY_W      = 16;
    localparam int RY_SH     = 29;
    localparam int PY_W      = RY_SH + QY_W;
    localparam int RW        = $clog2(BPC_DIV_BASE);         // remainder
    localparam int RR_SH     = 38;
    localparam int PR_W      = RR_SH + 1;
    localparam int QUOT_W    = Q1_W + FRAC_BITS;
    localparam int NSTEP     = 3;
    localparam int CW        = $clog2(NSTEP + 1);
    localparam int SW        = QUOT_W + 2;                   // signed sum
    localparam int PK_W  = BPC_GAIN_W + 1 + ES_W;            // kp*e
    localparam int PB_W  = PK_W + BPC_MULT_W + 1;            // p*mult
    localparam int DRV_W = PB_W + 2;

    // ceil(2^29 / 125) and ceil(2^38 / 125)
    localparam logic [PY_W-1:0] RECIP_Y = PY_W'(4294968);
    localparam logic [PR_W-1:0] RECIP_R = PR_W'(64'd2199023256);

    localparam logic signed [SW-1:0] SUM_HI = SW'(BPC_SNAP_HI) << FRAC_BITS;
    localparam logic signed [SW-1:0] SUM_LO = SW'(BPC_SNAP_LO) << FRAC_BITS;
    localparam logic [IW-1:0] INT_DOWN = IW'(BPC_JUMP_DOWN_TO) << FRAC_BITS;
    localparam logic [IW-1:0] INT_UP   = IW'(BPC_JUMP_UP_TO) << FRAC_BITS;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } t_band;

    // Configuration and state registers
    logic [BPC_GAIN_W-1:0]  r_kp, r_ki;
    logic [BPC_MULT_W-1:0]  r_bm;
    logic                   r_rev;
    logic [BPC_LEVEL_W-1:0] r_hold_min, r_hold_max;
    logic [IW-1:0]          r_integ, n_integ;
    logic                   r_auto;

    // Item registers
    logic [BPC_CMD_W-1:0]     r_command;
    logic [BPC_LEVEL_W-1:0]   r_held;
    logic signed [ES_W-1:0]   r_es, n_es;
    t_band                    r_band, n_band;
    logic [P1_W-1:0]          r_prod1;
    logic [XW-1:0]            r_prod2;
    logic signed [PK_W-1:0]   r_pk;
    logic signed [PK_W-1:0]   r_psh, n_psh;
    logic signed [PB_W-1:0]   r_pbm;
    logic [Q1_W-1:0]          r_qa, r_q1;
    logic [Y_W-1:0]           r_y;
    logic [QY_W-1:0]          r_qy;
    logic [RW-1:0]            r_r1;
    logic [FRAC_BITS-1:0]     r_q2;
    logic [CW-1:0]            r_div_cnt;
    logic [BPC_DRIVE_W-1:0]   r_out_drive, n_out_drive;
    logic                     r_out_upd;

    logic signed [EW-1:0]   e_raw, e_sh3, e_sh6;
    logic [EW-1:0]          e_mag;
    logic [MAG_W-1:0]       es_mag;
    logic                   inc_neg;
    logic signed [PK_W-1:0] p_dir;
    logic [XH_W-1:0]        x_hi;
    logic [DIV_SPLIT-1:0]   x_lo;
    logic [PY_W-1:0]        y_prod;
    logic [PR_W-1:0]        r1_prod;
    logic [QUOT_W-1:0]      quot;
    logic [QUOT_W-1:0]      inc;
    logic signed [SW-1:0]   s_int, s_inc, s_sum;
    logic [BPC_LEVEL_W-1:0] reload_val;
    logic                   mode_change;
    logic signed [DRV_W-1:0] drv;

    // Form the error and pick its band
    always_comb begin
        e_raw = $signed({1'b0, i_target_level}) - $signed({1'b0, i_measured_level});
        e_mag = e_raw[EW-1] ? EW'(-e_raw) : EW'(e_raw);
        e_sh3 = e_raw >>> 3;
        e_sh6 = e_raw >>> 6;
        if (e_mag < EW'(BPC_BAND_MID_MIN)) begin
            n_band = BAND_LOW;
            n_es   = e_raw[ES_W-1:0];
        end else if (e_mag < EW'(BPC_BAND_HIGH_MIN)) begin
            n_band = BAND_MID;
            n_es   = e_sh3[ES_W-1:0];
        end else begin
            n_band = BAND_HIGH;
            n_es   = e_sh6[ES_W-1:0];
        end
    end

    assign es_mag  = r_es[ES_W-1] ? MAG_W'(-r_es) : MAG_W'(r_es);
    assign inc_neg = r_es[ES_W-1] ^ r_rev;

    // Scale the proportional term by the band shift
    always_comb begin
        p_dir = r_rev ? -r_pk : r_pk;
        case (r_band)
            BAND_LOW: n_psh = p_dir >>> 9;
            BAND_MID: n_psh = p_dir >>> 6;
            default:  n_psh = p_dir >>> 3;
        endcase
    end

    // Split the dividend and form the reciprocal products
    assign x_hi    = r_prod2[XW-1:DIV_SPLIT];
    assign x_lo    = r_prod2[DIV_SPLIT-1:0];
    assign y_prod  = PY_W'(r_y) * RECIP_Y;
    assign r1_prod = PR_W'(r_r1) * RECIP_R;

    // Apply the power-of-two divisor factor, add and snap the integrator
    always_comb begin
        quot = {r_q1, r_q2};
        case (r_band)
            BAND_LOW: inc = quot >> 12;
            BAND_MID: inc = quot >> 9;
            default:  inc = quot >> 6;
        endcase
        s_int = SW'(r_integ);
        s_inc = SW'(inc);
        s_sum = inc_neg ? (s_int - s_inc) : (s_int + s_inc);
        if (s_sum > SUM_HI) begin
            n_integ = INT_DOWN;
        end else if (s_sum <= SUM_LO) begin
            n_integ = INT_UP;
        end else begin
            n_integ = s_sum[IW-1:0];
        end
    end

    // Clamp the held drive for a bumpless reload
    always_comb begin
        if (r_held > r_hold_max) begin
            reload_val = r_hold_max;
        end else if (r_held < r_hold_min) begin
            reload_val = r_hold_min;
        end else begin
            reload_val = r_held;
        end
        mode_change = ((r_command == CMD_AUTO) && !r_auto) ||
                      ((r_command == CMD_MANUAL) && r_auto);
    end

    // Sum integer part and P term, saturate to the drive range
    always_comb begin
        drv = $signed({1'b0, r_integ[IW-1:FRAC_BITS]}) + r_pbm;
        if (drv > DRV_W'(BPC_DRIVE_MAX)) begin
            n_out_drive = BPC_DRIVE_W'(BPC_DRIVE_MAX);
        end else if (drv < 0) begin
            n_out_drive = '0;
        end else begin
            n_out_drive = drv[BPC_DRIVE_W-1:0];
        end
    end

    // Configuration, integrator, mode and divider count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp       <= '0;
            r_ki       <= '0;
            r_bm       <= '0;
            r_rev      <= 1'b0;
            r_hold_min <= '0;
            r_hold_max <= BPC_HOLD_MAX_RST;
            r_integ    <= '0;
            r_auto     <= 1'b0;
            r_div_cnt  <= '0;
            r_out_upd  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROP_GAIN:  r_kp       <= i_cfg_data;
                    CFG_INTEG_GAIN: r_ki       <= i_cfg_data;
                    CFG_BAND_MULT:  r_bm       <= i_cfg_data[BPC_MULT_W-1:0];
                    CFG_REVERSE:    r_rev      <= i_cfg_data[0];
                    CFG_HOLD_MIN:   r_hold_min <= i_cfg_data;
                    CFG_HOLD_MAX:   r_hold_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.mode && mode_change) begin
                r_integ <= IW'(reload_val) << FRAC_BITS;
                r_auto  <= ~r_auto;
            end else if (i_cmd.update) begin
                r_integ <= n_integ;
            end
            if (i_cmd.mul3) begin
                r_div_cnt <= CW'(NSTEP);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_upd <= o_stat.sample_auto;
            end
        end
    end

    // Item payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_command <= i_command;
            r_held    <= i_held_drive;
            r_es      <= n_es;
            r_band    <= n_band;
        end
        if (i_cmd.mul1) begin
            r_prod1 <= r_ki * es_mag;
            r_pk    <= $signed({1'b0, r_kp}) * r_es;
        end
        if (i_cmd.mul2) begin
            r_prod2 <= r_prod1 * r_bm;
            r_psh   <= n_psh;
        end
        // Fold the dividend: x = 125 * (2097 * x_hi) + (19 * x_hi + x_lo)
        if (i_cmd.mul3) begin
            r_qa  <= Q1_W'(x_hi) * Q1_W'(DIV_HI_Q);
            r_y   <= Y_W'(x_hi) * Y_W'(DIV_FOLD) + Y_W'(x_lo);
            r_pbm <= r_psh * $signed({1'b0, r_bm});
        end
        // Advance the divide stages; each settles one step after its source
        if (i_cmd.div_step) begin
            r_qy <= y_prod[RY_SH +: QY_W];
            r_q1 <= r_qa + Q1_W'(r_qy);
            r_r1 <= RW'(r_y - Y_W'(r_qy) * Y_W'(BPC_DIV_BASE));
            r_q2 <= r1_prod[RR_SH-FRAC_BITS +: FRAC_BITS];
        end
        if (i_cmd.load_out) begin
            r_out_drive <= o_stat.sample_auto ? n_out_drive : '0;
        end
    end

    assign o_stat.sample_auto = (r_command == CMD_SAMPLE) && r_auto;
    assign o_stat.div_last    = (r_div_cnt == CW'(1));
    assign o_drive_value      = r_out_drive;
    assign o_drive_updated    = r_out_upd;

`ifndef SYNTHESIS
    // After an update the integrator lies inside the snap window
    a_integ_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (SW'(r_integ) > SUM_LO) && (SW'(r_integ) <= SUM_HI))
        else $error("integrator outside snap window after update");

    // The banded error always fits the narrowed range
    a_es_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.latch |=> (r_es >= -ES_W'(1024)) && (r_es <= ES_W'(1023)))
        else $error("banded error out of range");

    // A result that is not a fresh drive carries a zero value
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && !o_stat.sample_auto) |=> (r_out_drive == '0) && !r_out_upd)
        else $error("non-sample result carries a drive value");
`endif

endmodule

[src/bpc_controller.sv]
// Controller: sequences the datapath for one transfer and owns the output valid.
module bpc_controller import bpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_MUL1 = 8'b0000_0100,
        S_MUL2 = 8'b0000_1000,
        S_MUL3 = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_UPD  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Sequence one item through the datapath
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.sample_auto) begin
                    n_state = S_MUL1;
                end else begin
                    o_cmd.mode = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result until the receiver takes the transfer
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // The last divider step is followed by the integrator update
    a_div_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && i_stat.div_last) |=> o_cmd.update)
        else $error("integrator update missing after divide");

    // Only one item is in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while one is in work");
`endif

endmodule

[src/banded_pi_pressure_controller_core.sv]
// Top level: banded PI pressure controller core.
//
// Usage:
//   i_in carries one command per transfer: a sample (target and measured
//   level), enter automatic or enter manual (held drive for the bumpless
//   integrator reload). Every input transfer yields exactly one transfer on
//   o_out; only a sample taken in automatic mode sets drive_updated and
//   carries a new 10-bit drive, all other results are zero.
//   Gains, band multiplier, direction and hold limits are written through the
//   i_cfg_* port, one register per cycle with i_cfg_we high, while idle.
//   One item at a time. A sample in automatic goes from input transfer to
//   result through these steps: band the error, the chained multiplies,
//   the staged reciprocal divide by 125, update the integrator and load the
//   result. Other items apply any mode change and then load the result.
//   The input is ready again in the cycle after the result is loaded.
//   A finished result sits in the output register; the next input is taken
//   while it waits, and that item stalls only at its own result if the
//   receiver still holds off.
//   Reset (synchronous, active low) clears the integrator, selects manual
//   mode, restores register defaults and empties the output register.
module banded_pi_pressure_controller_core import bpc_pkg::*; #(
    parameter int FRAC_BITS = BPC_FRAC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bpc_in_if.sink                    i_in,
    bpc_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [BPC_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BPC_CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;
    logic     out_valid;

    // Sequencer
    bpc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic and state
    bpc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_in.command),
        .i_target_level   (i_in.target_level),
        .i_measured_level (i_in.measured_level),
        .i_held_drive     (i_in.held_drive),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .o_drive_value    (o_out.drive_value),
        .o_drive_updated  (o_out.drive_updated)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule
